// ===== src/colored_life_generation_engine_assert.svh =====
// Assertion macros for the colored life engine
`ifndef COLORED_LIFE_GENERATION_ENGINE_ASSERT_SVH
`define COLORED_LIFE_GENERATION_ENGINE_ASSERT_SVH
`ifndef ASSERT_OFF
`define CLGE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CLGE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CLGE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CLGE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/clge_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package clge_pkg;
    localparam int GRID_WIDTH  = 64;
    localparam int GRID_HEIGHT = 64;
    localparam int XW = 6;
    localparam int YW = 6;
    localparam int AW = XW + YW;
    localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;

    localparam logic [2:0] OP_SET    = 3'd0;
    localparam logic [2:0] OP_TOGGLE = 3'd1;
    localparam logic [2:0] OP_CLEAR  = 3'd2;
    localparam logic [2:0] OP_CLRALL = 3'd3;
    localparam logic [2:0] OP_GEN    = 3'd4;
    localparam logic [2:0] OP_READ   = 3'd5;

    localparam logic CFG_BIRTH   = 1'b0;
    localparam logic CFG_SURVIVE = 1'b1;

    typedef struct packed {
        logic [2:0] operation;
        logic [5:0] col_x;
        logic [5:0] row_y;
        logic [2:0] cell_color;
    } req_t;

    typedef struct packed {
        logic       read_alive;
        logic [2:0] read_color;
    } rsp_t;

    function automatic logic [5:0] color_weight(input logic [2:0] c);
        return {1'b0, c[2], 1'b0, c[1], 1'b0, c[0]};
    endfunction

    function automatic logic [2:0] newborn_color(input logic [5:0] s);
        logic [2:0] c;
        c = {s[5], s[3], s[1]};
        return (c == 3'd7) ? 3'd0 : c;
    endfunction
endpackage
`default_nettype wire

// ===== src/clge_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module clge_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== src/colored_life_generation_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel | direction | handshake           | payload
// req     | in        | req_valid/req_ready | req_t
// rsp     | out       | rsp_valid/rsp_ready | rsp_t
// cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
// Reset runs a clearing pass over all 4096 cells; no request is taken meanwhile.
// Cell ops go read, write, output to the response; unused codes go to output.
// Clear grid sweeps every cell. A generation reads each neighbour
// through one RAM read port, in an issue and an accumulate phase, one cell at a
// time, into a second bank, then a copy sweep writes that bank back to the grid.
// A result waits in the output register; next request is taken once it goes.
module colored_life_generation_engine import clge_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_ready,
    input  wire req_t       req,
    output logic            rsp_valid,
    input  wire logic       rsp_ready,
    output rsp_t            rsp,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_index,
    input  wire logic [8:0] cfg_data
);
`include "colored_life_generation_engine_assert.svh"
    typedef enum logic [7:0] {
        S_INIT  = 8'b00000001,
        S_IDLE  = 8'b00000010,
        S_RD    = 8'b00000100,
        S_WR    = 8'b00001000,
        S_CLR   = 8'b00010000,
        S_GEN   = 8'b00100000,
        S_COPY  = 8'b01000000,
        S_OUT   = 8'b10000000
    } state_t;

    // neighbour offsets by index, entry k in bits [2k+1:2k]
    localparam logic [17:0] DX_TAB = {2'd2, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0};
    localparam logic [17:0] DY_TAB = {2'd2, 2'd2, 2'd2, 2'd1, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0};

    state_t      state_reg, state_next;
    req_t        req_reg;
    logic [8:0]  birth_reg, survive_reg;
    logic [AW:0] cnt_reg, cnt_next;
    logic [3:0]  nb_reg, nb_next;
    logic [1:0]  ph_reg, ph_next;
    logic [3:0]  ncount_reg, ncount_next;
    logic [5:0]  sum_reg, sum_next;
    logic [3:0]  self_reg, self_next;
    logic        rsp_valid_reg;
    rsp_t        rsp_reg, rsp_next;
    logic        bank_valid_reg, bank_valid_next;

    logic          we_a, we_b;
    logic [AW-1:0] waddr_a, raddr_a, waddr_b, raddr_b;
    logic [3:0]    wdata_a, wdata_b, rdata_a, rdata_b;

    clge_ram #(.WIDTH(4), .DEPTH(CELLS)) u_grid (
        .clk(clk), .we(we_a), .waddr(waddr_a), .wdata(wdata_a),
        .raddr(raddr_a), .rdata(rdata_a));
    clge_ram #(.WIDTH(4), .DEPTH(CELLS)) u_next (
        .clk(clk), .we(we_b), .waddr(waddr_b), .wdata(wdata_b),
        .raddr(raddr_b), .rdata(rdata_b));

    logic [AW-1:0] cell_addr;
    logic [XW-1:0] cx;
    logic [YW-1:0] cy;
    logic signed [XW+1:0] nx;
    logic signed [YW+1:0] ny;
    logic          nb_in;
    logic [1:0]    dxi, dyi;
    logic          req_fire;

    assign cell_addr = cnt_reg[AW-1:0];
    assign cx = cell_addr[XW-1:0];
    assign cy = cell_addr[AW-1:XW];
    assign dxi = DX_TAB[{nb_reg, 1'b0} +: 2];
    assign dyi = DY_TAB[{nb_reg, 1'b0} +: 2];
    assign nx = $signed({2'b00, cx}) + $signed({6'd0, dxi}) - 8'sd1;
    assign ny = $signed({2'b00, cy}) + $signed({6'd0, dyi}) - 8'sd1;
    assign nb_in = (nx >= 0) && (nx < GRID_WIDTH) && (ny >= 0) && (ny < GRID_HEIGHT);

    assign req_ready = (state_reg == S_IDLE) && !rsp_valid_reg;
    assign req_fire  = req_valid && req_ready;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        nb_next = nb_reg;
        ph_next = ph_reg;
        ncount_next = ncount_reg;
        sum_next = sum_reg;
        self_next = self_reg;
        rsp_next = rsp_reg;
        bank_valid_next = bank_valid_reg;
        we_a = 1'b0;
        waddr_a = cell_addr;
        wdata_a = 4'd0;
        raddr_a = {req_reg.row_y, req_reg.col_x};
        we_b = 1'b0;
        waddr_b = cell_addr;
        wdata_b = 4'd0;
        raddr_b = cell_addr;
        case (state_reg)
            S_INIT, S_CLR:
            begin
                we_a = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[AW-1:0] == AW'(CELLS - 1))
                begin
                    cnt_next = '0;
                    rsp_next = '0;
                    state_next = (state_reg == S_INIT) ? S_IDLE : S_OUT;
                end
            end
            S_IDLE:
            begin
                if (req_fire)
                begin
                    rsp_next = '0;
                    cnt_next = '0;
                    nb_next = '0;
                    ph_next = '0;
                    ncount_next = '0;
                    sum_next = '0;
                    case (req.operation)
                        OP_SET, OP_TOGGLE, OP_CLEAR, OP_READ: state_next = S_RD;
                        OP_CLRALL: state_next = S_CLR;
                        OP_GEN:    state_next = S_GEN;
                        default:   state_next = S_OUT;
                    endcase
                end
            end
            S_RD:
            begin
                state_next = S_WR;
            end
            S_WR:
            begin
                waddr_a = {req_reg.row_y, req_reg.col_x};
                case (req_reg.operation)
                    OP_SET:
                    begin
                        we_a = 1'b1;
                        wdata_a = {1'b1, req_reg.cell_color};
                    end
                    OP_TOGGLE:
                    begin
                        we_a = 1'b1;
                        wdata_a = (rdata_a[3] && rdata_a[2:0] == req_reg.cell_color)
                                  ? 4'd0 : {1'b1, req_reg.cell_color};
                    end
                    OP_CLEAR: we_a = 1'b1;
                    OP_READ:
                    begin
                        rsp_next.read_alive = rdata_a[3];
                        rsp_next.read_color = rdata_a[3] ? rdata_a[2:0] : 3'd0;
                    end
                    default: we_a = 1'b0;
                endcase
                state_next = S_OUT;
            end
            S_GEN:
            begin
                raddr_a = {ny[YW-1:0], nx[XW-1:0]};
                // ph 0: issue read, ph 1: accumulate
                if (ph_reg == 2'd0)
                begin
                    ph_next = 2'd1;
                end
                else
                begin
                    ph_next = 2'd0;
                    if (nb_reg == 4'd4)
                    begin
                        self_next = rdata_a;
                    end
                    else if (nb_in && rdata_a[3])
                    begin
                        ncount_next = ncount_reg + 1'b1;
                        sum_next = sum_reg + color_weight(rdata_a[2:0]);
                    end
                    nb_next = nb_reg + 1'b1;
                    if (nb_reg == 4'd8)
                    begin
                        we_b = 1'b1;
                        if (self_reg[3])
                            wdata_b = (ncount_next != 0 && survive_reg[ncount_next])
                                      ? self_reg : 4'd0;
                        else
                            wdata_b = (ncount_next != 0 && birth_reg[ncount_next])
                                      ? {1'b1, newborn_color(sum_next)} : 4'd0;
                        nb_next = '0;
                        ncount_next = '0;
                        sum_next = '0;
                        cnt_next = cnt_reg + 1'b1;
                        if (cell_addr == AW'(CELLS - 1))
                        begin
                            cnt_next = '0;
                            state_next = S_COPY;
                        end
                    end
                end
            end
            S_COPY:
            begin
                raddr_b = cnt_reg[AW-1:0];
                if (bank_valid_reg)
                begin
                    we_a = 1'b1;
                    waddr_a = AW'(cnt_reg[AW-1:0] - 1'b1);
                    wdata_a = rdata_b;
                end
                bank_valid_next = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (AW+1)'(CELLS))
                begin
                    bank_valid_next = 1'b0;
                    cnt_next = '0;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            cnt_reg <= '0;
            nb_reg <= '0;
            ph_reg <= '0;
            rsp_valid_reg <= 1'b0;
            bank_valid_reg <= 1'b0;
            birth_reg <= 9'd8;
            survive_reg <= 9'd12;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            nb_reg <= nb_next;
            ph_reg <= ph_next;
            bank_valid_reg <= bank_valid_next;
            if (state_reg == S_OUT)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
            if (cfg_valid)
            begin
                if (cfg_index == CFG_BIRTH)
                    birth_reg <= cfg_data;
                else
                    survive_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
            req_reg <= req;
        ncount_reg <= ncount_next;
        sum_reg <= sum_next;
        self_reg <= self_next;
        rsp_reg <= rsp_next;
    end

    `CLGE_ASSERT_IMP(a_ready_idle, clk, rst_n, req_ready, state_reg == S_IDLE)
    `CLGE_ASSERT_NEXT(a_fire_leaves, clk, rst_n, req_fire, state_reg != S_IDLE)
    `CLGE_ASSERT_IMP(a_nb_range, clk, rst_n, state_reg == S_GEN, nb_reg <= 4'd8)
    `CLGE_ASSERT_NEXT(a_out_valid, clk, rst_n, state_reg == S_OUT, rsp_valid)
endmodule
`default_nettype wire

// ===== tb/colored_life_generation_engine_tb.sv =====
`timescale 1ns / 1ps
module colored_life_generation_engine_tb;
    import clge_pkg::*;

    localparam int STALL_LIMIT = 400000;
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    typedef struct {
        req_t r;
        bit   typed;
        rsp_t want;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_ready;
    req_t       req = '0;
    logic       rsp_valid;
    logic       rsp_ready = 1'b0;
    rsp_t       rsp;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_index = CFG_BIRTH;
    logic [8:0] cfg_data = '0;

    logic [3:0] life_cells [CELLS];
    logic [3:0] next_cells [CELLS];
    logic [8:0] birth_rule;
    logic [8:0] survive_rule;
    rsp_t       pending_reads [$];
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         errors = 0;
    int         quiet_cycles = 0;

    colored_life_generation_engine u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [2:0] birth_colour(input logic [5:0] s);
        logic [2:0] c;
        c[2] = s[5:4] >= 2'd2;
        c[1] = s[3:2] >= 2'd2;
        c[0] = s[1:0] >= 2'd2;
        return (c == 3'd7) ? 3'd0 : c;
    endfunction

    function automatic void step_generation();
        int n;
        int nx;
        int ny;
        logic [5:0] sum;
        logic [3:0] c;
        for (int y = 0; y < GRID_HEIGHT; y++)
        begin
            for (int x = 0; x < GRID_WIDTH; x++)
            begin
                n = 0;
                sum = '0;
                for (int dy = -1; dy <= 1; dy++)
                begin
                    for (int dx = -1; dx <= 1; dx++)
                    begin
                        nx = x + dx;
                        ny = y + dy;
                        if ((dx != 0 || dy != 0) && nx >= 0 && ny >= 0 &&
                            nx < GRID_WIDTH && ny < GRID_HEIGHT)
                        begin
                            c = life_cells[ny * GRID_WIDTH + nx];
                            if (c[3])
                            begin
                                n++;
                                sum = sum + {c[2], 4'd0} + {c[1], 2'd0} + c[0];
                            end
                        end
                    end
                end
                c = life_cells[y * GRID_WIDTH + x];
                if (c[3])
                    next_cells[y * GRID_WIDTH + x] = (n >= 1 && survive_rule[n]) ? c : 4'd0;
                else
                    next_cells[y * GRID_WIDTH + x] = (n >= 1 && birth_rule[n]) ?
                                                     {1'b1, birth_colour(sum)} : 4'd0;
            end
        end
        life_cells = next_cells;
    endfunction

    function automatic rsp_t apply_request(input req_t r);
        rsp_t o;
        int idx;
        o = '0;
        idx = r.row_y * GRID_WIDTH + r.col_x;
        case (r.operation)
            OP_SET:    life_cells[idx] = {1'b1, r.cell_color};
            OP_TOGGLE:
                if (life_cells[idx][3] && life_cells[idx][2:0] == r.cell_color)
                    life_cells[idx] = 4'd0;
                else
                    life_cells[idx] = {1'b1, r.cell_color};
            OP_CLEAR:  life_cells[idx] = 4'd0;
            OP_CLRALL:
                for (int i = 0; i < CELLS; i++)
                    life_cells[i] = 4'd0;
            OP_GEN:    step_generation();
            OP_READ:
                if (life_cells[idx][3])
                begin
                    o.read_alive = 1'b1;
                    o.read_color = life_cells[idx][2:0];
                end
            default: ;
        endcase
        return o;
    endfunction

    task automatic send_request(input req_t r, input bit typed, input rsp_t want);
        rsp_t got;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        got = apply_request(r);
        pending_reads.push_back(typed ? want : got);
        req_valid <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    task automatic write_rule(input logic idx, input logic [8:0] val);
        req_valid <= 1'b0;
        wait (pending_reads.size() == 0);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_BIRTH)
            birth_rule = val;
        else
            survive_rule = val;
    endtask

    function automatic req_t random_request();
        req_t r;
        int pick;
        int zone;
        pick = $urandom_range(99);
        if (pick < 38)       r.operation = OP_SET;
        else if (pick < 50)  r.operation = OP_TOGGLE;
        else if (pick < 58)  r.operation = OP_CLEAR;
        else if (pick < 90)  r.operation = OP_READ;
        else if (pick < 92)  r.operation = OP_CLRALL;
        else if (pick < 96)  r.operation = OP_GEN;
        else                 r.operation = pick[0] ? OP_SPARE_A : OP_SPARE_B;
        zone = $urandom_range(3);
        if (zone == 0)
        begin
            r.col_x = 6'($urandom_range(63));
            r.row_y = 6'($urandom_range(63));
        end
        else if (zone == 1)
        begin
            r.col_x = 6'd56 + 6'($urandom_range(7));
            r.row_y = 6'd56 + 6'($urandom_range(7));
        end
        else
        begin
            r.col_x = 6'($urandom_range(5));
            r.row_y = 6'($urandom_range(5));
        end
        r.cell_color = 3'($urandom_range(7));
        return r;
    endfunction

    always @(posedge clk)
    begin
        rsp_t want;
        if (rsp_valid && rsp_ready)
        begin
            if (pending_reads.size() == 0)
            begin
                $display("%0t: response with no request outstanding: %p", $time, rsp);
                errors++;
            end
            else
            begin
                want = pending_reads.pop_front();
                if (rsp.read_alive !== want.read_alive)
                begin
                    $display("%0t: read_alive expected %0d actual %0d",
                             $time, want.read_alive, rsp.read_alive);
                    errors++;
                end
                if (rsp.read_color !== want.read_color)
                begin
                    $display("%0t: read_color expected %0d actual %0d",
                             $time, want.read_color, rsp.read_color);
                    errors++;
                end
            end
        end
        rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    stim_row_t  directed [$];
    int         idle_set [4][2] = '{'{0, 0}, '{84, 0}, '{0, 84}, '{10, 10}};
    logic [8:0] birth_set [4];
    logic [8:0] survive_set [4];

    function automatic stim_row_t row(input logic [2:0] op, input int x, input int y,
                                      input int c, input bit typed, input int a,
                                      input int rc);
        stim_row_t s;
        s.r = '{operation: op, col_x: 6'(x), row_y: 6'(y), cell_color: 3'(c)};
        s.typed = typed;
        s.want = '{read_alive: 1'(a), read_color: 3'(rc)};
        return s;
    endfunction

    initial
    begin
        for (int i = 0; i < CELLS; i++)
            life_cells[i] = 4'd0;
        birth_rule = 9'd8;
        survive_rule = 9'd12;
        birth_set = '{9'h1FF, 9'h000, 9'd8, 9'($urandom_range(511))};
        survive_set = '{9'h000, 9'h1FF, 9'd12, 9'($urandom_range(511))};

        directed.push_back(row(OP_READ,   0,  0, 0, 1, 0, 0));
        directed.push_back(row(OP_READ,  63, 63, 7, 1, 0, 0));
        directed.push_back(row(OP_SET,    0,  0, 7, 1, 0, 0));
        directed.push_back(row(OP_READ,   0,  0, 0, 1, 1, 7));
        directed.push_back(row(OP_SET,   63, 63, 0, 1, 0, 0));
        directed.push_back(row(OP_READ,  63, 63, 0, 1, 1, 0));
        directed.push_back(row(OP_TOGGLE, 63, 63, 0, 0, 0, 0));
        directed.push_back(row(OP_READ,  63, 63, 0, 1, 0, 0));
        directed.push_back(row(OP_TOGGLE, 63, 0, 5, 0, 0, 0));
        directed.push_back(row(OP_TOGGLE, 63, 0, 2, 0, 0, 0));
        directed.push_back(row(OP_READ,  63,  0, 0, 1, 1, 2));
        directed.push_back(row(OP_CLEAR, 63,  0, 0, 0, 0, 0));
        directed.push_back(row(OP_READ,  63,  0, 0, 1, 0, 0));
        // cell beside the corner with mixed neighbours, and a row of mixed colours
        directed.push_back(row(OP_SET,    1,  0, 4, 0, 0, 0));
        directed.push_back(row(OP_SET,    0,  1, 4, 0, 0, 0));
        directed.push_back(row(OP_SET,   10, 10, 1, 0, 0, 0));
        directed.push_back(row(OP_SET,   11, 10, 2, 0, 0, 0));
        directed.push_back(row(OP_SET,   12, 10, 6, 0, 0, 0));
        directed.push_back(row(OP_GEN,    0,  0, 0, 0, 0, 0));
        directed.push_back(row(OP_READ,   1,  1, 0, 0, 0, 0));
        directed.push_back(row(OP_READ,  11,  9, 0, 0, 0, 0));
        directed.push_back(row(OP_READ,  11, 10, 0, 0, 0, 0));
        directed.push_back(row(OP_SPARE_A, 11, 10, 7, 1, 0, 0));
        directed.push_back(row(OP_SPARE_B, 0,  0, 7, 1, 0, 0));
        directed.push_back(row(OP_CLRALL, 0,  0, 0, 1, 0, 0));
        directed.push_back(row(OP_READ,  11, 10, 0, 1, 0, 0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            send_request(directed[i].r, directed[i].typed, directed[i].want);

        for (int p = 0; p < 4; p++)
        begin
            write_rule(CFG_BIRTH, birth_set[p]);
            write_rule(CFG_SURVIVE, survive_set[p]);
            send_idle_pct = idle_set[p][0];
            recv_stall_pct = idle_set[p][1];
            repeat (28)
                send_request(random_request(), 1'b0, '0);
        end
        req_valid <= 1'b0;

        wait (pending_reads.size() == 0);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+src
src/clge_pkg.sv
src/clge_ram.sv
src/colored_life_generation_engine.sv
tb/colored_life_generation_engine_tb.sv
